[design/sha2c_pkg.sv]
// shared types and constants for the shacal-2 block cipher
package sha2c_pkg;

    localparam int WORD_W    = 32;
    localparam int KEY_SLOTS = 64;
    localparam int KEY_IDX_W = $clog2(KEY_SLOTS);
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEC  = 2'd2;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [CMD_W-1:0]     cmd_code_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } block_t;

    // controller to datapath commands
    typedef struct packed {
        logic key_write;
        logic start;
        logic start_dec;
        logic step;
        logic capture;
    } dp_cmd_t;

endpackage

[design/sha2c_in_if.sv]
// input channel: command, round key and block words
interface sha2c_in_if;
    import sha2c_pkg::*;

    logic      valid;
    logic      ready;
    cmd_code_t cmd;
    key_idx_t  key_index;
    word_t     key_value;
    word_t     word_a;
    word_t     word_b;
    word_t     word_c;
    word_t     word_d;
    word_t     word_e;
    word_t     word_f;
    word_t     word_g;
    word_t     word_h;

    modport source (
        output valid, cmd, key_index, key_value,
        output word_a, word_b, word_c, word_d, word_e, word_f, word_g, word_h,
        input  ready
    );

    modport sink (
        input  valid, cmd, key_index, key_value,
        input  word_a, word_b, word_c, word_d, word_e, word_f, word_g, word_h,
        output ready
    );
endinterface

[design/sha2c_out_if.sv]
// output channel: result block words
interface sha2c_out_if;
    import sha2c_pkg::*;

    logic  valid;
    logic  ready;
    word_t out_a;
    word_t out_b;
    word_t out_c;
    word_t out_d;
    word_t out_e;
    word_t out_f;
    word_t out_g;
    word_t out_h;

    modport source (
        output valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
        input  ready
    );

    modport sink (
        input  valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
        output ready
    );
endinterface

[design/sha2c_ram.sv]
// generic simple dual-port ram with registered read
module sha2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[design/sha2c_ctrl.sv]
// control fsm: item acceptance, round count and result handoff
module sha2c_ctrl #(
    parameter int NUM_ROUNDS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha2c_pkg::cmd_code_t  in_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha2c_pkg::dp_cmd_t    dp_cmd
);
    import sha2c_pkg::*;

    localparam int RND_W = $clog2(NUM_ROUNDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             is_cipher;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign is_cipher = (in_cmd == CMD_ENC) || (in_cmd == CMD_DEC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        rnd_next          = rnd_reg;
        out_valid_next    = out_valid_reg & ~out_ready;
        dp_cmd            = '0;
        dp_cmd.start_dec  = (in_cmd == CMD_DEC);
        unique case (state_reg)
            ST_IDLE:
            begin
                dp_cmd.key_write = accept && (in_cmd == CMD_LOAD);
                dp_cmd.start     = accept && is_cipher;
                if (accept && is_cipher)
                begin
                    rnd_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                dp_cmd.step = 1'b1;
                rnd_next    = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(NUM_ROUNDS - 1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.capture = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[design/sha2c_dp.sv]
// datapath: round key store, working block, round logic, output register
module sha2c_dp #(
    parameter int NUM_ROUNDS = 64
) (
    input  logic                 clk,
    input  sha2c_pkg::dp_cmd_t   dp_cmd,
    input  sha2c_pkg::key_idx_t  key_index,
    input  sha2c_pkg::word_t     key_value,
    input  sha2c_pkg::block_t    blk_in,
    output sha2c_pkg::block_t    blk_out
);
    import sha2c_pkg::*;

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) | ((a | b) & c);
    endfunction

    function automatic block_t round_fwd(input block_t v, input word_t key);
        word_t  t1;
        word_t  t2;
        block_t r;
        t1  = v.h + big_sigma1(v.e) + choose(v.e, v.f, v.g) + key;
        t2  = big_sigma0(v.a) + majority(v.a, v.b, v.c);
        r.a = t1 + t2;
        r.b = v.a;
        r.c = v.b;
        r.d = v.c;
        r.e = v.d + t1;
        r.f = v.e;
        r.g = v.f;
        r.h = v.g;
        return r;
    endfunction

    function automatic block_t round_inv(input block_t v, input word_t key);
        word_t  t1;
        word_t  t2;
        block_t r;
        t2  = big_sigma0(v.b) + majority(v.b, v.c, v.d);
        t1  = v.a - t2;
        r.a = v.b;
        r.b = v.c;
        r.c = v.d;
        r.d = v.e - t1;
        r.e = v.f;
        r.f = v.g;
        r.g = v.h;
        r.h = t1 - big_sigma1(v.f) - choose(v.f, v.g, v.h) - key;
        return r;
    endfunction

    block_t   work_reg, work_next;
    block_t   out_reg;
    key_idx_t key_idx_reg, key_idx_next;
    logic     dec_reg;
    word_t    round_key;

    // key address runs one round ahead of the round logic
    always_comb
    begin
        priority if (dp_cmd.start)
        begin
            key_idx_next = dp_cmd.start_dec ? KEY_IDX_W'(NUM_ROUNDS - 1) : '0;
        end
        else if (dp_cmd.step)
        begin
            key_idx_next = dec_reg ? key_idx_reg - 1'b1 : key_idx_reg + 1'b1;
        end
        else
        begin
            key_idx_next = key_idx_reg;
        end
    end

    sha2c_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEY_SLOTS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (dp_cmd.key_write),
        .wr_addr (key_index),
        .wr_data (key_value),
        .rd_addr (key_idx_next),
        .rd_data (round_key)
    );

    always_comb
    begin
        priority if (dp_cmd.start)
        begin
            work_next = blk_in;
        end
        else if (dp_cmd.step)
        begin
            work_next = dec_reg ? round_inv(work_reg, round_key)
                                : round_fwd(work_reg, round_key);
        end
        else
        begin
            work_next = work_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        key_idx_reg <= key_idx_next;
        if (dp_cmd.start)
        begin
            dec_reg <= dp_cmd.start_dec;
        end
        if (dp_cmd.capture)
        begin
            out_reg <= work_reg;
        end
    end

    assign blk_out = out_reg;
endmodule

[design/shacal2_block_cipher.sv]
// top level of the shacal-2 block cipher
// SHACAL-2 on one 256-bit block (words a..h, big-endian) per item. A load
// item (cmd 0) writes one 32-bit round key into a 64-entry key store and
// returns nothing; an encrypt (cmd 1) or decrypt (cmd 2) item returns one
// result block; cmd 3 is taken and dropped. A cipher item runs one round per
// cycle through forward or inverse round logic that reads one key from the
// key store each cycle, so it occupies the engine for NUM_ROUNDS rounds plus
// a flush step that moves the block into the output register, and the next
// item is taken only once that step is done. The output register lets a new
// item start while a result still waits to be taken; only when the engine
// finishes while that register is still full does it hold until the result
// is taken. Keys must be loaded before the blocks that use them; the key
// store is not cleared at reset.
module shacal2_block_cipher #(
    parameter int NUM_ROUNDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    sha2c_in_if.sink    din,
    sha2c_out_if.source dout
);
    import sha2c_pkg::*;

    dp_cmd_t dp_cmd;
    block_t  blk_in;
    block_t  blk_out;

    // control: one item at a time, round counter, output valid
    sha2c_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .in_cmd    (din.cmd),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .dp_cmd    (dp_cmd)
    );

    assign blk_in.a = din.word_a;
    assign blk_in.b = din.word_b;
    assign blk_in.c = din.word_c;
    assign blk_in.d = din.word_d;
    assign blk_in.e = din.word_e;
    assign blk_in.f = din.word_f;
    assign blk_in.g = din.word_g;
    assign blk_in.h = din.word_h;

    // key store, working block and round logic
    sha2c_dp #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_dp (
        .clk       (clk),
        .dp_cmd    (dp_cmd),
        .key_index (din.key_index),
        .key_value (din.key_value),
        .blk_in    (blk_in),
        .blk_out   (blk_out)
    );

    assign dout.out_a = blk_out.a;
    assign dout.out_b = blk_out.b;
    assign dout.out_c = blk_out.c;
    assign dout.out_d = blk_out.d;
    assign dout.out_e = blk_out.e;
    assign dout.out_f = blk_out.f;
    assign dout.out_g = blk_out.g;
    assign dout.out_h = blk_out.h;
endmodule
